// ===== hw/rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the filtered position P controller
// Widths, register indexes, sequencer states and the multiplier control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int MAG_W    = SAMPLE_W;
    localparam int GAIN_W   = 16;
    localparam int ALPHA_W  = 9;
    localparam int SPEED_W  = 8;
    localparam int CMD_W    = SPEED_W + 1;
    localparam int OPA_W    = GAIN_W + 1;
    localparam int PROD_W   = OPA_W + DIFF_W;
    localparam int ACC_W    = SAMPLE_W + 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_GAIN      = 3'd1,
        REG_ALPHA     = 3'd2,
        REG_TOLERANCE = 3'd3,
        REG_DEADBAND  = 3'd4,
        REG_MIN_SPEED = 3'd5,
        REG_MAX_SPEED = 3'd6
    } t_cfg_reg;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_TARGET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_UPD,
        ST_ERR,
        ST_GAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic sel_gain;
    } t_mul_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/fpc_mul.sv =====
// ----------------------------------------------------------------------------
// fpc_mul: shared registered multiplier
// Multiplies either alpha by the sample difference or gain by the error
// magnitude, and holds the product until the next load.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_mul (
    input  wire logic                                 i_clk,
    input  wire fpc_pkg::t_mul_ctl                    i_ctl,
    input  wire logic [fpc_pkg::ALPHA_W-1:0]          i_alpha,
    input  wire logic signed [fpc_pkg::DIFF_W-1:0]    i_diff,
    input  wire logic [fpc_pkg::GAIN_W-1:0]           i_gain,
    input  wire logic [fpc_pkg::MAG_W-1:0]            i_mag,
    output logic signed [fpc_pkg::PROD_W-1:0]         o_prod
);
    import fpc_pkg::*;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [DIFF_W-1:0] op_b;
    logic signed [PROD_W-1:0] r_prod;

    always_comb begin
        if (i_ctl.sel_gain) begin
            op_a = $signed({1'b0, i_gain});
            op_b = $signed({1'b0, i_mag});
        end else begin
            op_a = $signed({{(OPA_W-ALPHA_W){1'b0}}, i_alpha});
            op_b = i_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hw/rtl/filtered_position_p_controller_core.sv =====
// ----------------------------------------------------------------------------
// filtered_position_p_controller_core: smoothed position P regulator
// Filters sensor samples, compares against the target and issues a limited
// velocity command with deadband through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+-----------------------------------------
//  in       | i_in_valid  | o_in_stall  | i_action, i_sensor_position, i_target_value
//  out      | o_out_valid | i_out_stall | o_speed_command, o_at_target
//  cfg      | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
//  Set-target and disabled-tick transactions are taken in idle and give no result.
//  Enabled ticks run the shared multiplier twice in sequence (filter weight,
//  then gain), with update and error steps between and the limit step last.
//  The next transaction is taken while a result waits in the output register;
//  a tick only waits in its last step if that register is full and stalled.
//  Reset is synchronous and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_position_p_controller_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_action,
    input  wire logic signed [fpc_pkg::SAMPLE_W-1:0]    i_sensor_position,
    input  wire logic signed [fpc_pkg::SAMPLE_W-1:0]    i_target_value,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [fpc_pkg::CMD_W-1:0]            o_speed_command,
    output logic                                        o_at_target,
    input  wire logic                                   i_cfg_we,
    input  wire logic [fpc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [fpc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import fpc_pkg::*;

    t_state r_state, n_state;

    logic                 r_enable;
    logic [GAIN_W-1:0]    r_gain;
    logic [ALPHA_W-1:0]   r_alpha;
    logic [15:0]          r_tolerance;
    logic [15:0]          r_deadband;
    logic [SPEED_W-1:0]   r_min_speed;
    logic [SPEED_W-1:0]   r_max_speed;

    logic signed [SAMPLE_W-1:0] r_smoothed;
    logic signed [SAMPLE_W-1:0] r_goal;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_primed;
    logic                       r_goal_set;

    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic                 r_at;
    logic                 r_zero;

    logic                     r_out_valid;
    logic signed [CMD_W-1:0]  r_speed;
    logic                     r_out_at;

    logic                       in_accept;
    logic                       out_free;
    t_mul_ctl                   mul_ctl;
    logic [ALPHA_W-1:0]         alpha_sat;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc;
    logic signed [DIFF_W-1:0]   err;
    logic [DIFF_W-1:0]          err_abs;
    logic [MAG_W+15:0]          rnd;
    logic [MAG_W-1:0]           spd_raw;
    logic [SPEED_W-1:0]         spd_lim;
    logic signed [CMD_W-1:0]    spd_cmd;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign diff      = $signed({r_sample[SAMPLE_W-1], r_sample})
                     - $signed({r_smoothed[SAMPLE_W-1], r_smoothed});

    fpc_mul u_mul (
        .i_clk   (i_clk),
        .i_ctl   (mul_ctl),
        .i_alpha (alpha_sat),
        .i_diff  (diff),
        .i_gain  (r_gain),
        .i_mag   (r_mag),
        .o_prod  (prod)
    );

    always_comb begin
        acc     = $signed({{2{r_smoothed[SAMPLE_W-1]}}, r_smoothed, 8'b0})
                + prod[ACC_W-1:0] + ACC_W'(128);
        err     = $signed({r_goal[SAMPLE_W-1], r_goal})
                - $signed({r_smoothed[SAMPLE_W-1], r_smoothed});
        err_abs = err[DIFF_W-1] ? DIFF_W'(-err) : DIFF_W'(err);
        rnd     = prod[MAG_W+15:0] + (MAG_W+16)'(32768);
        spd_raw = rnd[MAG_W+15:16];
        priority if (spd_raw > MAG_W'(r_max_speed)) begin
            spd_lim = r_max_speed;
        end else if (spd_raw < MAG_W'(r_min_speed)) begin
            spd_lim = (r_min_speed > r_max_speed) ? r_max_speed : r_min_speed;
        end else begin
            spd_lim = spd_raw[SPEED_W-1:0];
        end
        if (r_zero) begin
            spd_cmd = '0;
        end else if (r_neg) begin
            spd_cmd = -$signed({1'b0, spd_lim});
        end else begin
            spd_cmd = $signed({1'b0, spd_lim});
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_stall   = 1'b1;
        mul_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (in_accept && i_action == ACT_TICK && r_enable) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                mul_ctl.load = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_ERR;
            end
            ST_ERR: begin
                n_state = ST_GAIN;
            end
            ST_GAIN: begin
                mul_ctl.load     = 1'b1;
                mul_ctl.sel_gain = 1'b1;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_gain      <= GAIN_W'(328);
            r_alpha     <= ALPHA_W'(205);
            r_tolerance <= 16'd500;
            r_deadband  <= 16'd1000;
            r_min_speed <= SPEED_W'(10);
            r_max_speed <= SPEED_W'(60);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE:    r_enable    <= i_cfg_data[0];
                REG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_ALPHA:     r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                REG_TOLERANCE: r_tolerance <= i_cfg_data;
                REG_DEADBAND:  r_deadband  <= i_cfg_data;
                REG_MIN_SPEED: r_min_speed <= i_cfg_data[SPEED_W-1:0];
                REG_MAX_SPEED: r_max_speed <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // position state: take targets, prime on the first tick, filter in the update step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed <= '0;
            r_goal     <= '0;
            r_primed   <= 1'b0;
            r_goal_set <= 1'b0;
        end else if (in_accept) begin
            if (i_action == ACT_TARGET) begin
                r_goal     <= i_target_value;
                r_goal_set <= 1'b1;
            end else if (!r_primed) begin
                r_smoothed <= i_sensor_position;
                r_primed   <= 1'b1;
                if (!r_goal_set) begin
                    r_goal <= i_sensor_position;
                end
            end
        end else if (r_state == ST_UPD) begin
            r_smoothed <= acc[SAMPLE_W+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sensor_position;
        end
        if (r_state == ST_ERR) begin
            r_mag  <= err_abs[MAG_W-1:0];
            r_neg  <= err[DIFF_W-1];
            r_at   <= (err_abs[MAG_W-1:0] < MAG_W'(r_tolerance));
            r_zero <= (err_abs[MAG_W-1:0] < MAG_W'(r_tolerance))
                   || (err_abs[MAG_W-1:0] < MAG_W'(r_deadband));
        end
    end

    // output register: load in the last step, drop on delivery
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_speed  <= spd_cmd;
            r_out_at <= r_at;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed_command = r_speed;
    assign o_at_target     = r_out_at;

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result appeared outside the final step");

    a_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_at) |-> spd_cmd == '0)
        else $error("nonzero speed while at target");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && i_out_stall) |=> r_state == ST_DONE)
        else $error("final step left while output register full");

    a_busy_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> r_primed)
        else $error("filter running before first sample");

endmodule

`default_nettype wire
